// ----- hdl/ntfs_data_run_decoder_assert.svh -----
// Assertion helpers for the run list decoder checker.
`ifndef NTFS_DATA_RUN_DECODER_ASSERT_SVH
`define NTFS_DATA_RUN_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NTFSD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NTFSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ntfsd_pkg.sv -----
package ntfsd_pkg;

  localparam int unsigned BpcW     = 22;
  localparam int unsigned WordW    = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned ProdW    = HalfW + BpcW;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QIdxW    = $clog2(QDepth);

  localparam logic [BpcW-1:0] BpcReset   = 22'd4096;
  localparam logic [7:0]      HdrEnd     = 8'h00;
  localparam logic [7:0]      LenNibMask = 8'h0F;
  localparam logic [7:0]      OffNibMask = 8'hF0;
  localparam logic [7:0]      SignMask   = 8'h80;
  localparam logic [7:0]      ByteOnes   = 8'hff;
  localparam logic [3:0]      SizeMax    = 4'd8;

  // What the front hands to the back for each result.
  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_END,
    CMD_ERR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [WordW-1:0] len;   // run length in clusters
    logic [WordW-1:0] off;   // sign-extended cluster offset
  } cmd_t;

endpackage

// ----- hdl/ntfsd_if.sv -----
// Run list byte stream.
interface ntfsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_byte;
  modport source (output valid, output run_byte, input ready);
  modport sink   (input valid, input run_byte, output ready);
endinterface

// Decoded run results.
interface ntfsd_run_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] run_cluster;
  logic [63:0] run_clusters;
  logic [63:0] run_bytes;
  logic        list_end;
  logic        size_error;
  modport source (output valid, output run_cluster, output run_clusters,
                  output run_bytes, output list_end, output size_error, input ready);
  modport sink   (input valid, input run_cluster, input run_clusters,
                  input run_bytes, input list_end, input size_error, output ready);
endinterface

// Cluster size register write.
interface ntfsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [21:0] bytes_per_cluster;
  modport source (output valid, output bytes_per_cluster, input ready);
  modport sink   (input valid, input bytes_per_cluster, output ready);
endinterface

// ----- hdl/ntfs_data_run_decoder.sv -----
// Channel   Dir  Payload                                                    Transfer
// in_i      in   run_byte[7:0]                                              valid & ready
// cfg_i     in   bytes_per_cluster[21:0]                                    valid & ready
// out_o     out  run_cluster, run_clusters, run_bytes, list_end, size_error valid & ready
//
// One byte per cycle is taken; in_i.ready drops only when the 4-entry command queue is full.
// A result passes from the byte that completes it through the queue, multiply stage and output
// register to out_o; the byte count uses two 32x22 multiplies, added after the multiply stage.
// rst_ni clears the parser, queue, running cluster and output valid; cluster size resets
// to 4096. cfg_i is always ready. A stalled out_o backs up into the queue, then into in_i.
module ntfs_data_run_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntfsd_byte_if.sink  in_i,
  ntfsd_cfg_if.sink   cfg_i,
  ntfsd_run_if.source out_o
);

  logic [ntfsd_pkg::BpcW-1:0] bpc_q;

  logic            push;
  ntfsd_pkg::cmd_t push_cmd;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  ntfsd_pkg::cmd_t q_head;

  // Cluster size register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_q <= ntfsd_pkg::BpcReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      bpc_q <= cfg_i.bytes_per_cluster;
    end
  end

  ntfsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  ntfsd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  ntfsd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .bpc_i     (bpc_q),
    .out_o     (out_o)
  );

endmodule

// ----- hdl/ntfsd_front.sv -----
// Header/field parser: one byte per transfer, emits one command per result.
module ntfsd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ntfsd_byte_if.sink      in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ntfsd_pkg::cmd_t push_cmd_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  len_size_q, len_size_d;
  logic [3:0]  off_size_q, off_size_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [ntfsd_pkg::WordW-1:0] len_acc_q, len_acc_d;
  logic [ntfsd_pkg::WordW-1:0] off_acc_q, off_acc_d;

  logic        accept;
  logic [7:0]  b;
  logic [3:0]  cnt_inc;
  logic [3:0]  hdr_ls;
  logic [3:0]  hdr_os;
  logic [5:0]  sh_amt;
  logic [ntfsd_pkg::WordW-1:0] byte_sh;
  logic [ntfsd_pkg::WordW-1:0] off_ext;
  logic        sign_bit;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.run_byte;
  assign cnt_inc    = cnt_q + 4'd1;
  assign hdr_ls     = 4'(b & ntfsd_pkg::LenNibMask);
  assign hdr_os     = 4'((b & ntfsd_pkg::OffNibMask) >> 4);
  assign sh_amt     = {cnt_q[2:0], 3'b000};
  assign byte_sh    = ntfsd_pkg::WordW'(b) << sh_amt;
  assign sign_bit   = |(b & ntfsd_pkg::SignMask);

  // Offset with this byte merged, lanes above it filled with the sign
  always_comb begin
    off_ext = off_acc_q | byte_sh;
    for (int k = 0; k < 8; k++) begin
      if (3'(k) > cnt_q[2:0]) begin
        off_ext[k*8 +: 8] = sign_bit ? ntfsd_pkg::ByteOnes : 8'h00;
      end
    end
  end

  // Next state and command
  always_comb begin
    phase_d    = phase_q;
    len_size_d = len_size_q;
    off_size_d = off_size_q;
    cnt_d      = cnt_q;
    len_acc_d  = len_acc_q;
    off_acc_d  = off_acc_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: ntfsd_pkg::CMD_RUN, len: '0, off: '0};
    if (accept) begin
      unique case (phase_q)
        PH_LENGTH: begin
          len_acc_d = len_acc_q | byte_sh;
          cnt_d     = cnt_inc;
          if (cnt_inc >= len_size_q) begin
            cnt_d = '0;
            if (off_size_q == '0) begin
              push_o     = 1'b1;
              push_cmd_o = '{kind: ntfsd_pkg::CMD_RUN, len: len_acc_q | byte_sh, off: '0};
              phase_d    = PH_HEADER;
            end else begin
              phase_d = PH_OFFSET;
            end
          end
        end
        PH_OFFSET: begin
          off_acc_d = off_acc_q | byte_sh;
          cnt_d     = cnt_inc;
          if (cnt_inc >= off_size_q) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: ntfsd_pkg::CMD_RUN, len: len_acc_q, off: off_ext};
            phase_d    = PH_HEADER;
            cnt_d      = '0;
          end
        end
        PH_HEADER: begin
          cnt_d = '0;
          if (b == ntfsd_pkg::HdrEnd) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: ntfsd_pkg::CMD_END, len: '0, off: '0};
          end else if (hdr_ls > ntfsd_pkg::SizeMax || hdr_os > ntfsd_pkg::SizeMax) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: ntfsd_pkg::CMD_ERR, len: '0, off: '0};
          end else begin
            len_size_d = hdr_ls;
            off_size_d = hdr_os;
            len_acc_d  = '0;
            off_acc_d  = '0;
            phase_d    = (hdr_ls != '0) ? PH_LENGTH : PH_OFFSET;
          end
        end
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      len_size_q <= '0;
      off_size_q <= '0;
      cnt_q      <= '0;
      len_acc_q  <= '0;
      off_acc_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      len_size_q <= len_size_d;
      off_size_q <= off_size_d;
      cnt_q      <= cnt_d;
      len_acc_q  <= len_acc_d;
      off_acc_q  <= off_acc_d;
    end
  end

endmodule

// ----- hdl/ntfsd_queue.sv -----
// Small command queue between parser and arithmetic back end.
module ntfsd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ntfsd_pkg::cmd_t push_cmd_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output ntfsd_pkg::cmd_t head_o
);

  ntfsd_pkg::cmd_t entries_q [ntfsd_pkg::QDepth];
  logic [ntfsd_pkg::QIdxW-1:0] wr_ptr_q;
  logic [ntfsd_pkg::QIdxW-1:0] rd_ptr_q;
  logic [ntfsd_pkg::QIdxW:0]   count_q;

  assign full_o  = count_q == (ntfsd_pkg::QIdxW+1)'(ntfsd_pkg::QDepth);
  assign valid_o = count_q != '0;
  assign head_o  = entries_q[rd_ptr_q];

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hdl/ntfsd_back.sv -----
// Back end: running cluster, split byte-count multiply, saturation, output register.
module ntfsd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  ntfsd_pkg::cmd_t              q_head_i,
  output logic                         q_pop_o,
  input  logic [ntfsd_pkg::BpcW-1:0]   bpc_i,
  ntfsd_run_if.source                  out_o
);

  localparam int unsigned W = ntfsd_pkg::WordW;
  localparam int unsigned H = ntfsd_pkg::HalfW;
  localparam int unsigned P = ntfsd_pkg::ProdW;

  logic [W-1:0] cc_q, cc_d;

  // Stage 1: cluster and partial products
  logic                 s1_v_q;
  ntfsd_pkg::cmd_kind_e s1_kind_q;
  logic [W-1:0]         s1_cluster_q;
  logic [W-1:0]         s1_len_q;
  logic [P-1:0]         s1_plo_q;
  logic [P-1:0]         s1_phi_q;

  // Output register
  logic                 out_v_q;
  logic [W-1:0]         out_cluster_q;
  logic [W-1:0]         out_clusters_q;
  logic [W-1:0]         out_bytes_q;
  logic                 out_end_q;
  logic                 out_err_q;

  logic         out_free;
  logic         s1_adv;
  logic         s1_free;
  logic [P-1:0] plo;
  logic [P-1:0] phi;
  logic [W:0]   sum;
  logic         ovf;
  logic [W-1:0] bytes;
  logic         s1_run;

  assign out_free = !out_v_q || out_o.ready;
  assign s1_adv   = s1_v_q && out_free;
  assign s1_free  = !s1_v_q || out_free;
  assign q_pop_o  = q_valid_i && s1_free;

  assign plo = P'(q_head_i.len[H-1:0]) * P'(bpc_i);
  assign phi = P'(q_head_i.len[W-1:H]) * P'(bpc_i);

  // Running cluster number
  always_comb begin
    cc_d = cc_q;
    if (q_pop_o) begin
      case (q_head_i.kind)
        ntfsd_pkg::CMD_RUN: cc_d = cc_q + q_head_i.off;
        ntfsd_pkg::CMD_END: cc_d = '0;
        default:            cc_d = cc_q;
      endcase
    end
  end

  // Recombine halves and saturate
  assign sum    = {1'b0, s1_phi_q[H-1:0], {H{1'b0}}} + (W+1)'(s1_plo_q);
  assign ovf    = (|s1_phi_q[P-1:H]) || sum[W];
  assign bytes  = ovf ? {W{1'b1}} : sum[W-1:0];
  assign s1_run = s1_kind_q == ntfsd_pkg::CMD_RUN;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_kind_q    <= q_head_i.kind;
      s1_cluster_q <= cc_d;
      s1_len_q     <= q_head_i.len;
      s1_plo_q     <= plo;
      s1_phi_q     <= phi;
    end
    if (s1_adv) begin
      out_cluster_q  <= s1_run ? s1_cluster_q : '0;
      out_clusters_q <= s1_run ? s1_len_q : '0;
      out_bytes_q    <= s1_run ? bytes : '0;
      out_end_q      <= s1_kind_q == ntfsd_pkg::CMD_END;
      out_err_q      <= s1_kind_q == ntfsd_pkg::CMD_ERR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cc_q <= cc_d;
      if (s1_free) begin
        s1_v_q <= q_pop_o;
      end
      if (out_free) begin
        out_v_q <= s1_adv;
      end
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.run_cluster  = out_cluster_q;
  assign out_o.run_clusters = out_clusters_q;
  assign out_o.run_bytes    = out_bytes_q;
  assign out_o.list_end     = out_end_q;
  assign out_o.size_error   = out_err_q;

endmodule

// ----- hdl/ntfsd_checker.sv -----
`include "ntfs_data_run_decoder_assert.svh"

// Port-level checks on the result channel.
module ntfsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] run_cluster_i,
  input logic [63:0] run_clusters_i,
  input logic [63:0] run_bytes_i,
  input logic        list_end_i,
  input logic        size_error_i
);

  // A stalled result holds
  `NTFSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(run_cluster_i) && $stable(run_bytes_i) && $stable(list_end_i), "stalled result changed")

  // End and error flags are exclusive
  `NTFSD_ASSERT_SAME(a_flags_excl, clk_i, rst_ni, out_valid_i, !(list_end_i && size_error_i), "list_end with size_error")

  // End or error carries no run
  `NTFSD_ASSERT_SAME(a_flag_zero, clk_i, rst_ni, out_valid_i && (list_end_i || size_error_i), run_cluster_i == 64'd0 && run_clusters_i == 64'd0 && run_bytes_i == 64'd0, "flagged result carries run data")

  // Empty run has no bytes
  `NTFSD_ASSERT_SAME(a_zero_len, clk_i, rst_ni, out_valid_i && run_clusters_i == 64'd0, run_bytes_i == 64'd0, "bytes without clusters")

endmodule

bind ntfs_data_run_decoder ntfsd_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .run_cluster_i  (out_o.run_cluster),
  .run_clusters_i (out_o.run_clusters),
  .run_bytes_i    (out_o.run_bytes),
  .list_end_i     (out_o.list_end),
  .size_error_i   (out_o.size_error)
);

// ----- tb/ntfs_data_run_decoder_tb.sv -----
module ntfs_data_run_decoder_tb;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 8;

  typedef enum logic [1:0] {
    WAIT_HEADER,
    READ_LENGTH,
    READ_OFFSET
  } parse_state_e;

  typedef struct {
    logic signed [63:0] cluster;
    logic [63:0]        clusters;
    logic [63:0]        nbytes;
    logic               list_end;
    logic               size_error;
  } run_result_t;

  // Tracks the decoder state per accepted byte and holds the runs still owed.
  class run_scoreboard;
    logic [ntfsd_pkg::BpcW-1:0] cluster_size;
    parse_state_e    state;
    logic [3:0]      len_size;
    logic [3:0]      off_size;
    logic [3:0]      count;
    logic [63:0]     len_acc;
    logic [63:0]     off_acc;
    logic [63:0]     cur_cluster;
    run_result_t     expected_runs[$];
    int              errors;

    function new();
      cluster_size = ntfsd_pkg::BpcReset;
      state        = WAIT_HEADER;
      len_size     = '0;
      off_size     = '0;
      count        = '0;
      len_acc      = '0;
      off_acc      = '0;
      cur_cluster  = '0;
      errors       = 0;
    endfunction

    function bit at_header();
      return state == WAIT_HEADER;
    endfunction

    // Sign-extend the offset, advance the cluster, scale the length.
    function void close_run();
      logic [63:0] off;
      logic [85:0] prod;
      run_result_t run;
      int          nbits;
      off = off_acc;
      if (off_size > 0 && off_size < 8) begin
        nbits = off_size * 8;
        if (off[nbits-1]) off |= ~((64'd1 << nbits) - 64'd1);
      end
      cur_cluster += off;
      prod = 86'(len_acc) * 86'(cluster_size);
      run.cluster    = cur_cluster;
      run.clusters   = len_acc;
      run.nbytes     = (prod[85:64] != '0) ? '1 : prod[63:0];
      run.list_end   = 1'b0;
      run.size_error = 1'b0;
      expected_runs.push_back(run);
      state = WAIT_HEADER;
      count = '0;
    endfunction

    // Called for every accepted run list byte.
    function void take_byte(logic [7:0] b);
      run_result_t run;
      logic [3:0]  ls;
      logic [3:0]  os;
      run = '{default: '0};
      ls  = b[3:0];
      os  = b[7:4];
      case (state)
        READ_LENGTH: begin
          len_acc |= 64'(b) << {count[2:0], 3'b000};
          count++;
          if (count >= len_size) begin
            count = '0;
            if (off_size == 0) close_run();
            else state = READ_OFFSET;
          end
        end
        READ_OFFSET: begin
          off_acc |= 64'(b) << {count[2:0], 3'b000};
          count++;
          if (count >= off_size) close_run();
        end
        default: begin
          count = '0;
          if (b == ntfsd_pkg::HdrEnd) begin
            cur_cluster  = '0;
            run.list_end = 1'b1;
            expected_runs.push_back(run);
          end else if (ls > ntfsd_pkg::SizeMax || os > ntfsd_pkg::SizeMax) begin
            run.size_error = 1'b1;
            expected_runs.push_back(run);
          end else begin
            len_size = ls;
            off_size = os;
            len_acc  = '0;
            off_acc  = '0;
            state    = (ls > 0) ? READ_LENGTH : READ_OFFSET;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] exp, logic [63:0] got);
      if (exp !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
        errors++;
      end
    endfunction

    // Called for every accepted result transfer.
    function void check_run(run_result_t got);
      run_result_t exp;
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cluster %h clusters %h",
                 $time, got.cluster, got.clusters);
        errors++;
        return;
      end
      exp = expected_runs.pop_front();
      compare_field("run_cluster", exp.cluster, got.cluster);
      compare_field("run_clusters", exp.clusters, got.clusters);
      compare_field("run_bytes", exp.nbytes, got.nbytes);
      compare_field("list_end", 64'(exp.list_end), 64'(got.list_end));
      compare_field("size_error", 64'(exp.size_error), 64'(got.size_error));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   bytes_sent;
  int   cycles;

  run_scoreboard sb;

  ntfsd_byte_if in_if ();
  ntfsd_cfg_if  cfg_if ();
  ntfsd_run_if  out_if ();

  ntfs_data_run_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random backpressure, check every transfer.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_run('{cluster: out_if.run_cluster, clusters: out_if.run_clusters,
                     nbytes: out_if.run_bytes, list_end: out_if.list_end,
                     size_error: out_if.size_error});
    end
    out_if.ready <= steady || ($urandom_range(99) >= 20);
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // One byte transfer, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.run_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // Drain all owed results and let the pipeline empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cluster_size(input logic [ntfsd_pkg::BpcW-1:0] v);
    settle();
    cfg_if.valid             <= 1'b1;
    cfg_if.bytes_per_cluster <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.cluster_size = v;
  endtask

  // Length and offset bytes lean toward zero and all ones.
  function automatic logic [7:0] field_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_run(input logic [3:0] ls, input logic [3:0] os);
    send_byte({os, ls});
    repeat (int'(ls) + int'(os)) send_byte(field_byte());
  endtask

  // Mostly well-formed runs, plus list ends, bad headers and stray bytes.
  task automatic run_random(input int n);
    int          stop;
    int          pick;
    logic [3:0]  ls;
    logic [3:0]  os;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_byte(ntfsd_pkg::HdrEnd);
      end else if (pick < 14) begin
        send_byte(8'($urandom));
      end else if (pick < 22) begin
        ls = 4'($urandom_range(15, 9));
        os = 4'($urandom);
        if ($urandom_range(1)) send_byte({ls, os});
        else send_byte({os, ls});
      end else begin
        ls = 4'($urandom_range(8));
        os = 4'($urandom_range(8));
        if (ls == 0 && os == 0) ls = 4'd1;
        send_run(ls, os);
      end
    end
    // get back to a header boundary before the phase ends
    while (!sb.at_header()) send_byte(8'h00);
  endtask

  initial begin
    in_if.valid              = 1'b0;
    in_if.run_byte           = '0;
    cfg_if.valid             = 1'b0;
    cfg_if.bytes_per_cluster = '0;
    out_if.ready             = 1'b0;
    rst_n                    = 1'b0;
    steady                   = 1'b0;
    bytes_sent               = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: end of list, negative offset, no offset, no length,
    // saturating length, bad sizes, zero bytes as data.
    send_byte(ntfsd_pkg::HdrEnd);
    send_byte(8'h11); send_byte(8'hFF); send_byte(8'h80);
    send_byte(8'h01); send_byte(8'h05);
    send_byte(8'h10); send_byte(8'h7F);
    send_byte(8'h18); repeat (8) send_byte(8'hFF); send_byte(8'h00);
    send_byte(8'h09);
    send_byte(8'hF0);
    send_byte(8'h11); send_byte(8'h00); send_byte(8'h00);
    send_byte(ntfsd_pkg::HdrEnd);

    run_random(250);
    write_cluster_size(22'd1);
    run_random(200);
    write_cluster_size(22'd0);
    run_random(150);
    write_cluster_size(22'd2097152);
    steady = 1'b1;
    run_random(250);
    write_cluster_size('1);
    steady = 1'b0;
    run_random(200);
    write_cluster_size(ntfsd_pkg::BpcW'($urandom_range(2097152, 1)));
    run_random(150);

    settle();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
